@@ design/assert_macros.svh @@
// Concurrent assertion helpers, sampled on clk_i, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ design/dlr_pkg.sv @@
`timescale 1ns / 1ps

package dlr_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 16;
  localparam int DASH_BITS  = 16;
  localparam int MODE_BITS  = 2;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int REM_BITS   = COORD_BITS + 1;

  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  localparam logic [MODE_BITS-1:0] MODE_SOLID       = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_TRANSLUCENT = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_DASHED      = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_TWO_COLOR   = 2'd3;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [MODE_BITS-1:0]  draw_mode;
    logic [DASH_BITS-1:0]  dash_len;
    logic [COLOR_BITS-1:0] color_a;
    logic [COLOR_BITS-1:0] color_b;
  } req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  write_pixel;
    logic                  translucent;
    logic                  last_pixel;
  } pix_t;

  // Input register towards the core.
  typedef struct packed {
    logic valid;
    req_t req;
  } stage_t;

  // Core status seen by the top level.
  typedef struct packed {
    logic                 take;
    logic                 busy;
    logic [MODE_BITS-1:0] mode;
  } core_status_t;

endpackage

@@ design/dashed_line_rasterizer.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                Payload
// request   in         in_valid_i / in_ready_o  in_data_i  (req_t)
// pixel     out        out_valid_o / out_ready_i out_data_o (pix_t)
//
// A request transaction passes through the input register, and Bresenham step and segment logic
// feed the pixel register on out_data_o. One request per cycle while the pixel output is not stalled.
// Loads and advances with no active line produce no pixel.
// Reset (rst_ni low, asynchronous) leaves no line active.
// A stalled pixel register holds the core; the input register still takes one request.

module dashed_line_rasterizer
  import dlr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output pix_t out_data_o
);

  `include "assert_macros.svh"

  stage_t       stage;
  core_status_t status;

  dlr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (status.take),
    .stage_o    (stage)
  );

  dlr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .status_o    (status)
  );

  `ASSERT_IMPLIES(a_last_ends_line, out_valid_o && out_data_o.last_pixel, !status.busy, "line still active after last pixel")
  `ASSERT_IMPLIES(a_gap_only_dashed, out_valid_o && !out_data_o.write_pixel, status.mode == MODE_DASHED, "dash gap outside dashed mode")
  `ASSERT_IMPLIES(a_stall_cause, !in_ready_o, stage.valid && out_valid_o && !out_ready_i, "input stalled without a blocked pixel")
  `ASSERT_NEVER(a_take_without_item, status.take && !stage.valid, "core took an empty stage")

endmodule

@@ design/dlr_in_reg.sv @@
`timescale 1ns / 1ps

module dlr_in_reg
  import dlr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  req_t   in_data_i,
  input  logic   take_i,
  output stage_t stage_o
);

  logic valid_q, valid_d;
  req_t req_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_data_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.req   = req_q;

endmodule

@@ design/dlr_core.sv @@
`timescale 1ns / 1ps

module dlr_core
  import dlr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  stage_t       stage_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output pix_t         out_data_o,
  output core_status_t status_o
);

  logic                       busy_q, busy_d;
  logic [COORD_BITS-1:0]      cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic                       x_neg_q, x_neg_d, y_neg_q, y_neg_d, x_major_q, x_major_d;
  logic signed [ERR_BITS-1:0] err_q, err_d, inc_str_q, inc_str_d, inc_diag_q, inc_diag_d;
  logic [REM_BITS-1:0]        rem_q, rem_d;
  logic [DASH_BITS-1:0]       seg_cnt_q, seg_cnt_d, seg_len_q, seg_len_d;
  logic                       seg_tog_q, seg_tog_d;
  logic [MODE_BITS-1:0]       mode_q, mode_d;
  logic [COLOR_BITS-1:0]      col_a_q, col_a_d, col_b_q, col_b_d;
  logic                       out_valid_q, out_valid_d;
  pix_t                       out_q, out_d;

  logic                       take;
  logic [COORD_BITS-1:0]      dx, dy, major, minor;
  logic signed [ERR_BITS-1:0] two_minor, two_major;
  logic [DASH_BITS-1:0]       seg_inc;
  logic                       diag;

  assign take = stage_i.valid && (!out_valid_q || out_ready_i);

  always_comb begin
    dx        = (stage_i.req.start_x > stage_i.req.end_x) ?
                stage_i.req.start_x - stage_i.req.end_x :
                stage_i.req.end_x - stage_i.req.start_x;
    dy        = (stage_i.req.start_y > stage_i.req.end_y) ?
                stage_i.req.start_y - stage_i.req.end_y :
                stage_i.req.end_y - stage_i.req.start_y;
    major     = (dx >= dy) ? dx : dy;
    minor     = (dx >= dy) ? dy : dx;
    two_minor = ERR_BITS'({minor, 1'b0});
    two_major = ERR_BITS'({major, 1'b0});
    seg_inc   = seg_cnt_q + DASH_BITS'(1);
    diag      = !err_q[ERR_BITS-1] && (err_q != ERR_BITS'(0));

    busy_d      = busy_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    x_neg_d     = x_neg_q;
    y_neg_d     = y_neg_q;
    x_major_d   = x_major_q;
    err_d       = err_q;
    inc_str_d   = inc_str_q;
    inc_diag_d  = inc_diag_q;
    rem_d       = rem_q;
    seg_cnt_d   = seg_cnt_q;
    seg_len_d   = seg_len_q;
    seg_tog_d   = seg_tog_q;
    mode_d      = mode_q;
    col_a_d     = col_a_q;
    col_b_d     = col_b_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    if (take) begin
      if (stage_i.req.req_type == REQ_LOAD) begin
        x_neg_d    = stage_i.req.start_x > stage_i.req.end_x;
        y_neg_d    = stage_i.req.start_y > stage_i.req.end_y;
        x_major_d  = dx >= dy;
        inc_str_d  = two_minor;
        inc_diag_d = two_minor - two_major;
        err_d      = two_minor - ERR_BITS'(major);
        rem_d      = REM_BITS'(major) + REM_BITS'(1);
        cur_x_d    = stage_i.req.start_x;
        cur_y_d    = stage_i.req.start_y;
        mode_d     = stage_i.req.draw_mode;
        seg_len_d  = stage_i.req.dash_len;
        col_a_d    = stage_i.req.color_a;
        col_b_d    = stage_i.req.color_b;
        seg_cnt_d  = '0;
        seg_tog_d  = 1'b0;
        busy_d     = 1'b1;
      end else if (busy_q) begin
        out_valid_d       = 1'b1;
        out_d.pixel_x     = cur_x_q;
        out_d.pixel_y     = cur_y_q;
        out_d.pixel_color = (mode_q == MODE_TWO_COLOR && seg_tog_q) ? col_b_q : col_a_q;
        out_d.write_pixel = !(mode_q == MODE_DASHED && seg_tog_q);
        out_d.translucent = mode_q == MODE_TRANSLUCENT;
        out_d.last_pixel  = rem_q == REM_BITS'(1);

        if (seg_len_q != '0 && seg_inc == seg_len_q) begin
          seg_cnt_d = '0;
          seg_tog_d = !seg_tog_q;
        end else begin
          seg_cnt_d = seg_inc;
        end

        if (diag || x_major_q) begin
          cur_x_d = x_neg_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
        end
        if (diag || !x_major_q) begin
          cur_y_d = y_neg_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
        end
        err_d  = diag ? err_q + inc_diag_q : err_q + inc_str_q;
        rem_d  = rem_q - REM_BITS'(1);
        busy_d = rem_q != REM_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      x_neg_q     <= 1'b0;
      y_neg_q     <= 1'b0;
      x_major_q   <= 1'b0;
      err_q       <= '0;
      inc_str_q   <= '0;
      inc_diag_q  <= '0;
      rem_q       <= '0;
      seg_cnt_q   <= '0;
      seg_len_q   <= '0;
      seg_tog_q   <= 1'b0;
      mode_q      <= MODE_SOLID;
      col_a_q     <= '0;
      col_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      x_neg_q     <= x_neg_d;
      y_neg_q     <= y_neg_d;
      x_major_q   <= x_major_d;
      err_q       <= err_d;
      inc_str_q   <= inc_str_d;
      inc_diag_q  <= inc_diag_d;
      rem_q       <= rem_d;
      seg_cnt_q   <= seg_cnt_d;
      seg_len_q   <= seg_len_d;
      seg_tog_q   <= seg_tog_d;
      mode_q      <= mode_d;
      col_a_q     <= col_a_d;
      col_b_q     <= col_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;
  assign status_o.take = take;
  assign status_o.busy = busy_q;
  assign status_o.mode = mode_q;

endmodule
